### src/cdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, operation codes and status codes of the circular deque buffer.
package cdb_pkg;

    // Storage depth default and the capacity register after reset.
    localparam int          DEPTH_DEF = 128;
    localparam logic [7:0]  CAP_RESET = 8'd128;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [2:0]         t_func;
    typedef logic [63:0]        t_tag;
    typedef logic signed [15:0] t_grade;
    typedef logic [1:0]         t_status;
    typedef logic [7:0]         t_count;

    // One stored entry.
    typedef struct packed {
        t_tag   tag;
        t_grade grade;
    } t_entry;

    // Store access strobes from the controller.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_cmd;

    // Result side information that travels beside the store read.
    typedef struct packed {
        logic    pop_ok;
        t_status status;
        t_count  count;
        logic    full;
        logic    empty;
    } t_rsp_info;

endpackage
`default_nettype wire

### src/cdb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request and response channel interfaces of the circular deque buffer.
interface cdb_req_if;
    logic               valid;
    logic               ready;
    cdb_pkg::t_func     func;
    cdb_pkg::t_tag      entry_tag;
    cdb_pkg::t_grade    entry_grade;

    modport source (output valid, output func, output entry_tag, output entry_grade,
                    input ready);
    modport sink   (input valid, input func, input entry_tag, input entry_grade,
                    output ready);
endinterface

interface cdb_rsp_if;
    logic               valid;
    logic               ready;
    cdb_pkg::t_tag      out_tag;
    cdb_pkg::t_grade    out_grade;
    cdb_pkg::t_status   status;
    cdb_pkg::t_count    fill_count;
    logic               is_full;
    logic               is_empty;

    modport source (output valid, output out_tag, output out_grade, output status,
                    output fill_count, output is_full, output is_empty, input ready);
    modport sink   (input valid, input out_tag, input out_grade, input status,
                    input fill_count, input is_full, input is_empty, output ready);
endinterface
`default_nettype wire

### src/cdb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-port entry store with a registered read port.
module cdb_store #(
    parameter int DEPTH = cdb_pkg::DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire cdb_pkg::t_mem_cmd          i_cmd,
    input  wire logic [$clog2(DEPTH)-1:0]   i_addr,
    input  wire cdb_pkg::t_entry            i_wdata,
    output cdb_pkg::t_entry                 o_rdata
);

    cdb_pkg::t_entry r_mem [DEPTH];
    cdb_pkg::t_entry r_rdata;

    // Write on a push, read on a pop; the read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/cdb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Pointer, count and capacity control of the circular deque buffer.
module cdb_ctrl #(
    parameter int DEPTH = cdb_pkg::DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [7:0]                 i_cfg_wdata,
    input  wire logic                       i_accept,
    input  wire cdb_pkg::t_func             i_func,
    input  wire cdb_pkg::t_tag              i_tag,
    input  wire cdb_pkg::t_grade            i_grade,
    output cdb_pkg::t_mem_cmd               o_cmd,
    output logic [$clog2(DEPTH)-1:0]        o_addr,
    output cdb_pkg::t_entry                 o_wdata,
    output cdb_pkg::t_rsp_info              o_info
);

    localparam int AW      = $clog2(DEPTH);
    // Largest capacity that can take effect: the store depth or the register range.
    localparam int CAP_LIM = (DEPTH > 255) ? 255 : DEPTH;
    localparam int PTR_W   = $clog2(CAP_LIM);

    logic [7:0]       r_cap;
    logic [PTR_W-1:0] r_front, n_front;
    logic [PTR_W-1:0] r_back,  n_back;
    cdb_pkg::t_count  r_count, n_count;

    logic [7:0]       eff_cap;
    logic             is_full_now;
    logic             is_empty_now;
    logic [PTR_W-1:0] front_up, front_dn, back_dn;

    // Forward step, wrapping to zero once the successor reaches the capacity.
    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                                 input logic [7:0] cap);
        logic [8:0] s;
        s = {1'b0, 8'(p)} + 9'd1;
        if (s >= {1'b0, cap}) begin
            return '0;
        end
        return PTR_W'(s);
    endfunction

    // Backward step, wrapping from zero (or from beyond the capacity) to the top.
    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                   input logic [7:0] cap);
        if (p == '0 || 8'(p) > cap) begin
            return PTR_W'(cap - 8'd1);
        end
        return p - PTR_W'(1);
    endfunction

    // Effective capacity: zero acts as one, values beyond the store are clipped.
    always_comb begin
        if (r_cap == 8'd0) begin
            eff_cap = 8'd1;
        end else if (r_cap > 8'(CAP_LIM)) begin
            eff_cap = 8'(CAP_LIM);
        end else begin
            eff_cap = r_cap;
        end
    end

    assign is_full_now  = (r_count >= eff_cap);
    assign is_empty_now = (r_count == '0);
    assign front_up     = step_up(r_front, eff_cap);
    assign front_dn     = step_down(r_front, eff_cap);
    assign back_dn      = step_down(r_back, eff_cap);
    assign o_wdata      = '{tag: i_tag, grade: i_grade};

    // Decode the operation into pointer updates and at most one store access.
    always_comb begin
        n_front       = r_front;
        n_back        = r_back;
        n_count       = r_count;
        o_cmd         = '0;
        o_addr        = AW'(r_front);
        o_info.pop_ok = 1'b0;
        o_info.status = cdb_pkg::ST_DONE;
        case (i_func)
            cdb_pkg::FUNC_PUSH_FRONT: begin
                if (is_full_now) begin
                    o_info.status = cdb_pkg::ST_FULL;
                end else begin
                    n_front  = front_dn;
                    o_addr   = AW'(front_dn);
                    o_cmd.we = i_accept;
                    n_count  = r_count + 8'd1;
                end
            end
            cdb_pkg::FUNC_PUSH_BACK: begin
                if (is_full_now) begin
                    o_info.status = cdb_pkg::ST_FULL;
                end else begin
                    o_addr   = AW'(r_back);
                    o_cmd.we = i_accept;
                    n_back   = step_up(r_back, eff_cap);
                    n_count  = r_count + 8'd1;
                end
            end
            cdb_pkg::FUNC_POP_FRONT: begin
                if (is_empty_now) begin
                    o_info.status = cdb_pkg::ST_EMPTY;
                end else begin
                    o_addr        = AW'(r_front);
                    o_cmd.re      = i_accept;
                    o_info.pop_ok = 1'b1;
                    n_front       = front_up;
                    n_count       = r_count - 8'd1;
                end
            end
            cdb_pkg::FUNC_POP_BACK: begin
                if (is_empty_now) begin
                    o_info.status = cdb_pkg::ST_EMPTY;
                end else begin
                    n_back        = back_dn;
                    o_addr        = AW'(back_dn);
                    o_cmd.re      = i_accept;
                    o_info.pop_ok = 1'b1;
                    n_count       = r_count - 8'd1;
                end
            end
            cdb_pkg::FUNC_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        o_info.count = n_count;
        o_info.full  = (n_count >= eff_cap);
        o_info.empty = (n_count == '0);
    end

    // Control registers and the capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= cdb_pkg::CAP_RESET;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

### src/circular_deque_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Circular deque buffer: a double-ended queue of tag and grade entries in one synchronous
// store. Each accepted item (push front, push back, pop front, pop back or clear) yields
// exactly one result item in the next cycle, and a new item is taken every cycle while the
// result side keeps up: the item touches the single store port at most once, and the pointers
// and count update in the same cycle, so a pop right after a push sees the new entry. The
// result stays in an output register while the sink stalls, and the request side is held
// only while that register is full and not being taken. A push onto a full deque is dropped
// with status full, a pop on an empty deque returns zeros with status empty. The user must write
// the capacity register with i_cfg_we only while no item is in flight; the block does not
// enforce it. Zero capacity acts as one, above DEPTH as DEPTH; the store needs no reset clearing.
module circular_deque_buffer_unit #(
    parameter int DEPTH = cdb_pkg::DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    cdb_req_if.sink     i_req,
    cdb_rsp_if.source   o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                  accept;
    cdb_pkg::t_mem_cmd     mem_cmd;
    logic [AW-1:0]         mem_addr;
    cdb_pkg::t_entry       mem_wdata;
    cdb_pkg::t_entry       mem_rdata;
    cdb_pkg::t_rsp_info    info;
    cdb_pkg::t_rsp_info    r_info;
    logic                  r_vld;

    // An item enters when the output register is empty or being drained.
    assign i_req.ready = !r_vld || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    cdb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_func      (i_req.func),
        .i_tag       (i_req.entry_tag),
        .i_grade     (i_req.entry_grade),
        .o_cmd       (mem_cmd),
        .o_addr      (mem_addr),
        .o_wdata     (mem_wdata),
        .o_info      (info)
    );

    cdb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Output stage: valid flag and the side information of the pending result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_info <= info;
        end
    end

    // The popped entry comes straight from the store read register.
    assign o_rsp.valid      = r_vld;
    assign o_rsp.out_tag    = r_info.pop_ok ? mem_rdata.tag : '0;
    assign o_rsp.out_grade  = r_info.pop_ok ? mem_rdata.grade : '0;
    assign o_rsp.status     = r_info.status;
    assign o_rsp.fill_count = r_info.count;
    assign o_rsp.is_full    = r_info.full;
    assign o_rsp.is_empty   = r_info.empty;

endmodule
`default_nettype wire

### src/cdb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the circular deque buffer and their binding to the top level.
module cdb_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire cdb_pkg::t_func      i_func,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire cdb_pkg::t_tag       i_out_tag,
    input wire cdb_pkg::t_grade     i_out_grade,
    input wire cdb_pkg::t_status    i_status,
    input wire cdb_pkg::t_count     i_fill_count,
    input wire logic                i_is_empty
);

    // Every accepted item shows its result in the following cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted item produced no result");

    // A clear leaves an empty deque behind.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_func == cdb_pkg::FUNC_CLEAR) |=>
        (i_fill_count == '0 && i_is_empty && i_status == cdb_pkg::ST_DONE))
        else $error("clear did not empty the deque");

    // A pop on an empty deque returns zeros and reports empty.
    a_empty_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == cdb_pkg::ST_EMPTY) |->
        (i_out_tag == '0 && i_out_grade == '0 && i_is_empty))
        else $error("pop on empty returned data");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_tag) && $stable(i_out_grade) &&
         $stable(i_status) && $stable(i_fill_count)))
        else $error("stalled result changed");

endmodule

bind circular_deque_buffer_unit cdb_checker u_cdb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_func       (i_req.func),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_tag    (o_rsp.out_tag),
    .i_out_grade  (o_rsp.out_grade),
    .i_status     (o_rsp.status),
    .i_fill_count (o_rsp.fill_count),
    .i_is_empty   (o_rsp.is_empty)
);
`default_nettype wire
